/* hdl/dtym_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtym_pkg
// Shared types, constants and helper functions of the differential thrust
// yaw mixer.
// ----------------------------------------------------------------------------
package dtym_pkg;

   localparam int WIDTH_BITS = 11;
   localparam int SUM_BITS   = 22;

   localparam logic [WIDTH_BITS-1:0] IDLE_WIDTH    = 11'd1000;
   localparam logic [WIDTH_BITS-1:0] MIN_RUN_WIDTH = 11'd1125;
   localparam logic [WIDTH_BITS-1:0] MAX_WIDTH     = 11'd1350;

   localparam logic signed [7:0] THRUST_DEADBAND = 8'sd5;
   localparam logic signed [7:0] THRUST_LIMIT    = 8'sd113;
   localparam logic signed [7:0] HARD_TURN_RIGHT = 8'sd63;
   localparam logic signed [7:0] HARD_TURN_LEFT  = -8'sd64;

   localparam logic       CONTROL_LAW_RESET = 1'b1;
   localparam logic [7:0] YAW_GAIN_RESET    = 8'd25;

   localparam logic REG_CONTROL_LAW = 1'b0;
   localparam logic REG_YAW_GAIN    = 1'b1;

   typedef enum logic [1:0] {
      CMD_START    = 2'd0,
      CMD_SHUTDOWN = 2'd1,
      CMD_UPDATE   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      BRAKE_NONE    = 2'd0,
      BRAKE_APPLY   = 2'd1,
      BRAKE_RELEASE = 2'd2
   } brake_event_type;

   // Limits a signed sum to the top width; anything below the run floor idles.
   function automatic logic [WIDTH_BITS-1:0] limit_width(input logic signed [SUM_BITS-1:0] w);
      logic [WIDTH_BITS-1:0] result;
      if (w > $signed({11'd0, MAX_WIDTH})) begin
         result = MAX_WIDTH;
      end else if (w < $signed({11'd0, MIN_RUN_WIDTH})) begin
         result = IDLE_WIDTH;
      end else begin
         result = w[WIDTH_BITS-1:0];
      end
      return result;
   endfunction

endpackage

/* hdl/differential_thrust_yaw_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_thrust_yaw_mixer
// Two-propeller hovercraft drive mixer with start-up and shut-down modes.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one event per transfer: the event kind in tuser and
// thrust, orientation, brake request and measured yaw rate in tdata. Each
// transfer produces exactly one rsp transfer with the motor enable, the port
// and starboard pulse widths and a brake change code.
// An accepted item is held in an input register and its result is loaded into
// the output register once that register is free, which raises rsp_tvalid.
// One item is taken in every cycle while the output is not stalled; the rate
// is set by the single combinational mixing pass with one 9 by 20 bit multiply.
// When rsp_tready is low the result holds and the input register still takes
// one more item; after that req_tready follows rsp_tready.
// Reset leaves the block uncontrolled with both props at 1000 us, the brake
// released and the registers at their defaults. The APB port writes
// control_law_enable at 0x0 and yaw_gain at 0x4 and may be read back.
// ----------------------------------------------------------------------------
module differential_thrust_yaw_mixer
   import dtym_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: thrust_byte[7:0], orient_byte[15:8], brake_request[16], yaw_rate[32:17]
   input  logic [39:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: motors_enabled[0], port_width[11:1], starboard_width[22:12],
   // brake_event[24:23]
   output logic [31:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                    control_law_ff;
   logic [7:0]              yaw_gain_ff;

   logic                    s1_valid_ff;
   cmd_type                 s1_cmd_ff;
   logic signed [7:0]       s1_thrust_ff;
   logic signed [7:0]       s1_orient_ff;
   logic                    s1_brake_ff;
   logic signed [15:0]      s1_yaw_ff;

   logic                    mode_ff, mode_in;
   logic                    brake_ff, brake_in;
   logic [WIDTH_BITS-1:0]   port_ff, port_in;
   logic [WIDTH_BITS-1:0]   stbd_ff, stbd_in;
   brake_event_type         event_in;

   logic                    rsp_valid_ff;
   logic [31:0]             rsp_data_ff;

   logic                    advance;
   logic                    csr_write;

   logic [WIDTH_BITS-1:0]   base;
   logic                    moving;
   logic signed [19:0]      err;
   logic signed [27:0]      prod;
   logic signed [20:0]      steer_p;
   logic signed [20:0]      steer_s;
   logic signed [8:0]       half_sum;
   logic signed [7:0]       half;
   logic signed [SUM_BITS-1:0] p_sum;
   logic signed [SUM_BITS-1:0] s_sum;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_YAW_GAIN) ? {24'd0, yaw_gain_ff}
                                                      : {31'd0, control_law_ff};

   always_comb begin
      moving = 1'b0;
      base   = IDLE_WIDTH;
      if (s1_thrust_ff <= THRUST_DEADBAND) begin
         moving = 1'b0;
         base   = IDLE_WIDTH;
      end else if (s1_thrust_ff <= THRUST_LIMIT) begin
         moving = 1'b1;
         base   = MIN_RUN_WIDTH - 11'd10 + {3'd0, s1_thrust_ff[6:0], 1'b0};
      end else begin
         moving = 1'b1;
         base   = MAX_WIDTH;
      end

      err      = (20'(s1_orient_ff) <<< 3) + 20'(s1_orient_ff) - (20'(s1_yaw_ff) <<< 3);
      prod     = $signed({1'b0, yaw_gain_ff}) * err;
      steer_p  = 21'(prod >>> 7);
      steer_s  = 21'((-prod) >>> 7);
      half_sum = 9'(s1_orient_ff) + $signed({8'd0, s1_orient_ff[7]});
      half     = 8'(half_sum >>> 1);

      p_sum = $signed({11'd0, base});
      s_sum = $signed({11'd0, base});
      if (moving) begin
         if (control_law_ff) begin
            p_sum = $signed({11'd0, base}) + 22'(steer_p);
            s_sum = $signed({11'd0, base}) + 22'(steer_s);
         end else begin
            p_sum = $signed({11'd0, base}) + 22'(half);
            s_sum = $signed({11'd0, base}) - 22'(half);
         end
      end else if (s1_orient_ff > HARD_TURN_RIGHT) begin
         p_sum = $signed({11'd0, MIN_RUN_WIDTH}) + $signed({14'd0, s1_orient_ff[5:0], 2'b00});
      end else if (s1_orient_ff < HARD_TURN_LEFT) begin
         s_sum = $signed({11'd0, MIN_RUN_WIDTH})
               + ((22'(HARD_TURN_LEFT) - 22'(s1_orient_ff)) <<< 2);
      end

      mode_in  = mode_ff;
      brake_in = brake_ff;
      port_in  = port_ff;
      stbd_in  = stbd_ff;
      event_in = BRAKE_NONE;
      if (!mode_ff) begin
         if (s1_cmd_ff == CMD_START) begin
            mode_in = 1'b1;
         end
      end else if (s1_cmd_ff == CMD_SHUTDOWN) begin
         mode_in = 1'b0;
         port_in = IDLE_WIDTH;
         stbd_in = IDLE_WIDTH;
      end else begin
         port_in = limit_width(p_sum);
         stbd_in = limit_width(s_sum);
         if (s1_brake_ff) begin
            if (!brake_ff) begin
               brake_in = 1'b1;
               event_in = BRAKE_APPLY;
            end
         end else if (brake_ff) begin
            brake_in = 1'b0;
            event_in = BRAKE_RELEASE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_law_ff <= CONTROL_LAW_RESET;
         yaw_gain_ff    <= YAW_GAIN_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == REG_YAW_GAIN) begin
            yaw_gain_ff <= csr_pwdata[7:0];
         end else begin
            control_law_ff <= csr_pwdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff    <= cmd_type'(req_tuser);
         s1_thrust_ff <= $signed(req_tdata[7:0]);
         s1_orient_ff <= $signed(req_tdata[15:8]);
         s1_brake_ff  <= req_tdata[16];
         s1_yaw_ff    <= $signed(req_tdata[32:17]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         brake_ff     <= 1'b0;
         port_ff      <= IDLE_WIDTH;
         stbd_ff      <= IDLE_WIDTH;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         mode_ff      <= mode_in;
         brake_ff     <= brake_in;
         port_ff      <= port_in;
         stbd_ff      <= stbd_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {7'd0, event_in, stbd_in, port_in, mode_in};
      end
   end

`ifndef NO_ASSERTIONS
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[11:1] == IDLE_WIDTH) ||
                       ((rsp_data_ff[11:1] >= MIN_RUN_WIDTH) &&
                        (rsp_data_ff[11:1] <= MAX_WIDTH)))
      else $error("port width out of range");

   a_idle_when_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[0]) |->
         (rsp_data_ff[11:1] == IDLE_WIDTH) && (rsp_data_ff[22:12] == IDLE_WIDTH) &&
         (rsp_data_ff[24:23] == BRAKE_NONE))
      else $error("uncontrolled result not idle");

   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[24:23] != 2'd3))
      else $error("invalid brake event code");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a full pipeline");

   a_start_enters_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && !mode_ff && (s1_cmd_ff == CMD_START)) |=> mode_ff)
      else $error("start event did not enter controlled mode");
`endif

endmodule

/* verif/tb_differential_thrust_yaw_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_differential_thrust_yaw_mixer
// Self-checking bench for the hovercraft drive mixer. A short table of
// directed events opens the run, some with hand-written results. Random
// phases follow under several gain and control law settings, with bursts of
// idle cycles on both streams. Every response transfer is compared field by
// field with its hand-written result or the one predicted at its acceptance.
// ----------------------------------------------------------------------------
module tb_differential_thrust_yaw_mixer;
   import dtym_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int IDLE_US   = IDLE_WIDTH;
   localparam int RUN_US    = MIN_RUN_WIDTH;
   localparam int MAX_US    = MAX_WIDTH;
   localparam int DEADBAND  = THRUST_DEADBAND;
   localparam int FULL_T    = THRUST_LIMIT;
   localparam int TURN_R    = HARD_TURN_RIGHT;
   localparam int TURN_L    = HARD_TURN_LEFT;
   localparam int IDLE_LIMIT = 1000;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [7:0]         thrust;
      logic [7:0]         orient;
      logic               brake;
      logic signed [15:0] yaw;
   } drive_cmd_type;

   typedef struct packed {
      logic            motors;
      logic [10:0]     port;
      logic [10:0]     stbd;
      brake_event_type brake_evt;
   } mix_out_type;

   typedef struct packed {
      drive_cmd_type item;
      logic          fixed;
      mix_out_type   want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Hand-written result travelling alongside the request it belongs to.
   logic        row_fixed = 1'b0;
   mix_out_type row_want = '0;

   logic        law_q, mode_q, brake_q;
   logic [7:0]  gain_q;
   logic [10:0] port_q, stbd_q;
   mix_out_type pending_mix[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          hold_cnt = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   logic        quiet = 1'b0;

   row_type directed_rows [0:23] = '{
      '{'{CMD_UPDATE, 8'd100, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b0, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_SHUTDOWN, 8'h00, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b0, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_SPARE, 8'h00, 8'h00, 1'b1, 16'h0000}, 1'b1,
        '{1'b0, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_START, 8'h00, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'h00, 8'h00, 1'b1, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_APPLY}},
      '{'{CMD_UPDATE, 8'h7F, 8'h00, 1'b1, 16'h0000}, 1'b1,
        '{1'b1, MAX_WIDTH, MAX_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'h80, 8'h7F, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, MAX_WIDTH, IDLE_WIDTH, BRAKE_RELEASE}},
      '{'{CMD_UPDATE, 8'd5, 8'h40, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, MIN_RUN_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'd5, 8'h3F, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'd5, 8'hC0, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'd5, 8'hBF, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, 11'd1129, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'hFF, 8'h80, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, MAX_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'd6, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, 11'd1127, 11'd1127, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'd113, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, 11'd1341, 11'd1341, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'd114, 8'h80, 1'b0, 16'h7FFF}, 1'b0, '0},
      '{'{CMD_UPDATE, 8'd60, 8'h7F, 1'b0, 16'h8000}, 1'b0, '0},
      '{'{CMD_START, 8'd50, 8'd10, 1'b0, 16'h0005}, 1'b0, '0},
      '{'{CMD_SPARE, 8'd6, 8'h80, 1'b0, 16'h0000}, 1'b0, '0},
      '{'{CMD_UPDATE, 8'd100, 8'hFF, 1'b1, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_SHUTDOWN, 8'h00, 8'h00, 1'b1, 16'h0000}, 1'b1,
        '{1'b0, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_START, 8'h00, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'h00, 8'h00, 1'b1, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_NONE}},
      '{'{CMD_UPDATE, 8'h00, 8'h00, 1'b0, 16'h0000}, 1'b1,
        '{1'b1, IDLE_WIDTH, IDLE_WIDTH, BRAKE_RELEASE}},
      '{'{CMD_UPDATE, 8'h55, 8'hAA, 1'b1, 16'h5555}, 1'b0, '0}
   };

   differential_thrust_yaw_mixer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [10:0] clamp_width(input int w);
      if (w > MAX_US) begin
         return MAX_WIDTH;
      end else if (w < RUN_US) begin
         return IDLE_WIDTH;
      end
      return w[10:0];
   endfunction

   // Applies one event to the mixer state and returns the response it causes.
   function automatic mix_out_type advance_mixer(input drive_cmd_type c);
      int t, o, y, base, p, s, steer;
      logic moving;
      mix_out_type r;
      t = $signed(c.thrust);
      o = $signed(c.orient);
      y = c.yaw;
      r.brake_evt = BRAKE_NONE;
      if (!mode_q) begin
         if (c.cmd == CMD_START) begin
            mode_q = 1'b1;
         end
      end else if (c.cmd == CMD_SHUTDOWN) begin
         mode_q = 1'b0;
         port_q = IDLE_WIDTH;
         stbd_q = IDLE_WIDTH;
      end else begin
         if (t <= DEADBAND) begin
            moving = 1'b0;
            base = IDLE_US;
         end else if (t <= FULL_T) begin
            moving = 1'b1;
            base = RUN_US + 2 * (t - DEADBAND);
         end else begin
            moving = 1'b1;
            base = MAX_US;
         end
         p = base;
         s = base;
         if (moving) begin
            if (law_q) begin
               steer = int'(gain_q) * (9 * o - 8 * y);
               p = base + (steer >>> 7);
               s = base + ((-steer) >>> 7);
            end else begin
               p = base + o / 2;
               s = base - o / 2;
            end
         end else if (o > TURN_R) begin
            p = RUN_US + 4 * (o - (TURN_R + 1));
         end else if (o < TURN_L) begin
            s = RUN_US + 4 * (TURN_L - o);
         end
         port_q = clamp_width(p);
         stbd_q = clamp_width(s);
         if (c.brake && !brake_q) begin
            brake_q = 1'b1;
            r.brake_evt = BRAKE_APPLY;
         end else if (!c.brake && brake_q) begin
            brake_q = 1'b0;
            r.brake_evt = BRAKE_RELEASE;
         end
      end
      r.motors = mode_q;
      r.port = port_q;
      r.stbd = stbd_q;
      return r;
   endfunction

   always @(posedge clock) begin : mixer_monitor
      mix_out_type got, want;
      if (reset) begin
         law_q = CONTROL_LAW_RESET;
         gain_q = YAW_GAIN_RESET;
         mode_q = 1'b0;
         brake_q = 1'b0;
         port_q = IDLE_WIDTH;
         stbd_q = IDLE_WIDTH;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_CONTROL_LAW, 2'b00}) begin
               law_q = csr_pwdata[0];
            end else if (csr_paddr == {REG_YAW_GAIN, 2'b00}) begin
               gain_q = csr_pwdata[7:0];
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.motors = rsp_tdata[0];
            got.port = rsp_tdata[11:1];
            got.stbd = rsp_tdata[22:12];
            got.brake_evt = brake_event_type'(rsp_tdata[24:23]);
            if (pending_mix.size() == 0) begin
               $error("response transfer with no result pending: %h", rsp_tdata);
               errors++;
            end else begin
               want = pending_mix.pop_front();
               if (got.motors !== want.motors) begin
                  $error("motors_enabled expected %0d got %0d", want.motors, got.motors);
                  errors++;
               end
               if (got.port !== want.port) begin
                  $error("port_width expected %0d got %0d", want.port, got.port);
                  errors++;
               end
               if (got.stbd !== want.stbd) begin
                  $error("starboard_width expected %0d got %0d", want.stbd, got.stbd);
                  errors++;
               end
               if (got.brake_evt !== want.brake_evt) begin
                  $error("brake_event expected %0d got %0d", want.brake_evt, got.brake_evt);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            want = advance_mixer(drive_cmd_type'({req_tuser, req_tdata[7:0], req_tdata[15:8],
                                                  req_tdata[16], req_tdata[32:17]}));
            pending_mix.push_back(row_fixed ? row_want : want);
         end
      end
   end

   always @(posedge clock) begin
      if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (!reset && !quiet && $urandom_range(99) < stall_pct) begin
         hold_cnt <= $urandom_range(5, 0);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_differential_thrust_yaw_mixer NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_cmd(input drive_cmd_type c, input logic fixed, input mix_out_type want);
      if (!quiet && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c.cmd;
      req_tdata <= {7'd0, c.yaw, c.brake, c.orient, c.thrust};
      row_fixed <= fixed;
      row_want <= want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_mixer_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic drive_cmd_type random_cmd(input logic after_shutdown);
      drive_cmd_type c;
      int pick;
      pick = $urandom_range(99);
      if (after_shutdown && pick < 70) begin
         c.cmd = CMD_START;
      end else begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            c.cmd = CMD_START;
         end else if (pick < 8) begin
            c.cmd = CMD_SHUTDOWN;
         end else if (pick < 12) begin
            c.cmd = CMD_SPARE;
         end else begin
            c.cmd = CMD_UPDATE;
         end
      end
      case ($urandom_range(3))
         0: c.thrust = 8'($urandom_range(255));
         1: c.thrust = 8'($urandom_range(8, 2));
         2: c.thrust = 8'($urandom_range(116, 110));
         default: c.thrust = 8'($urandom_range(113, 6));
      endcase
      c.orient = 8'($urandom_range(255));
      case ($urandom_range(2))
         0: c.yaw = 16'($urandom_range(65535));
         1: c.yaw = 16'(int'($urandom_range(400)) - 200);
         default: c.yaw = 16'((9 * int'($signed(c.orient))) / 8 + int'($urandom_range(80)) - 40);
      endcase
      c.brake = 1'($urandom_range(1));
      return c;
   endfunction

   initial begin : stimulus
      drive_cmd_type c;
      logic law;
      logic [7:0] gain;
      logic last_shut;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 20;
      stall_pct = 20;
      foreach (directed_rows[i]) begin
         send_cmd(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
      end
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin law = 1'b1; gain = 8'd0;   gap_pct = 25; stall_pct = 20; end
            1: begin law = 1'b1; gain = 8'd255; gap_pct = 0;  stall_pct = 35; end
            2: begin law = 1'b0; gain = 8'($urandom_range(254, 1));
                     gap_pct = 40; stall_pct = 0; end
            3: begin law = 1'b0; gain = 8'd255; gap_pct = 15; stall_pct = 40; end
            4: begin law = 1'b1; gain = 8'($urandom_range(254, 1));
                     gap_pct = 30; stall_pct = 15; end
            default: begin law = 1'b1; gain = YAW_GAIN_RESET; gap_pct = 0; stall_pct = 0; end
         endcase
         wait_mixer_idle();
         write_csr(REG_CONTROL_LAW, {31'd0, law});
         write_csr(REG_YAW_GAIN, {24'd0, gain});
         quiet = (phase == 5);
         last_shut = 1'b0;
         for (int n = 0; n < 100; n++) begin
            if (phase == 2 && n == 50) begin
               wait_mixer_idle();
            end
            c = random_cmd(last_shut);
            last_shut = (c.cmd == CMD_SHUTDOWN);
            send_cmd(c, 1'b0, '0);
         end
      end
      wait_mixer_idle();
      repeat (4) @(posedge clock);
      if (errors == 0 && pending_mix.size() == 0) begin
         $display("tb_differential_thrust_yaw_mixer OK");
      end else begin
         $display("tb_differential_thrust_yaw_mixer NOT OK");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/dtym_pkg.sv
hdl/differential_thrust_yaw_mixer.sv
verif/tb_differential_thrust_yaw_mixer.sv
